[hw/rtl/crp_pkg.sv]
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants of the pushback character reader.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam int CHAR_W = 21;
    localparam int LINE_W = 24;
    localparam int COL_W  = 24;
    localparam int POS_W  = 32;

    localparam logic [0:0]        OP_NEXT      = 1'b0;
    localparam logic [0:0]        OP_PUSHBACK  = 1'b1;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
    localparam logic [CHAR_W-1:0] INVALID_CODE_RESET = CHAR_W'(65533);

    typedef struct packed {
        logic [0:0]        opcode;
        logic [CHAR_W-1:0] source_char;
        logic              source_error;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [POS_W-1:0]  position;
        logic              from_pushback;
    } out_word_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [POS_W-1:0]  position;
    } tag_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        tag_t              tag;
    } hist_entry_t;

endpackage

[hw/rtl/char_reader_with_pushback_top.sv]
// ----------------------------------------------------------------------------
// char_reader_with_pushback_top
// Character front end for a tokenizer with a history ring and pushback.
// ----------------------------------------------------------------------------
// A fresh character appears on the output in the cycle after its word is
// taken; a replayed one passes the single, registered read port of the
// history memory and then the output register. Fresh characters and push
// backs are taken one per cycle unless the output is held; a replay blocks
// the input while its read is pending. Reset clears all counters; the history
// memory needs no clearing pass and is never read before it is written.
module char_reader_with_pushback_top #(
    parameter int DEPTH = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [crp_pkg::CHAR_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  crp_pkg::in_word_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output crp_pkg::out_word_t             out_data
);
    import crp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CHAR_W-1:0] invalid_code_reg;
    logic [AW-1:0]     tail_reg,     tail_next;
    logic [CW-1:0]     hist_cnt_reg, hist_cnt_next;
    logic [CW-1:0]     pb_cnt_reg,   pb_cnt_next;
    logic              rd_pend_reg,  rd_pend_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_data_reg,  out_data_next;

    logic              in_accept;
    logic              do_next;
    logic              do_replay;
    logic              do_fresh;
    logic [CHAR_W-1:0] fresh_char;
    logic [AW-1:0]     tail_inc;
    logic [AW-1:0]     tail_dec;
    tag_t              fresh_tag;
    hist_entry_t       wr_entry;
    hist_entry_t       rd_entry;

    assign in_stall  = rd_pend_reg || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign do_next   = in_accept && (in_data.opcode == OP_NEXT);
    assign do_replay = do_next && (pb_cnt_reg != '0);
    assign do_fresh  = do_next && (pb_cnt_reg == '0);

    assign fresh_char = in_data.source_error ? invalid_code_reg : in_data.source_char;
    assign tail_inc   = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
    assign tail_dec   = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - AW'(1);

    assign wr_entry.character = fresh_char;
    assign wr_entry.tag       = fresh_tag;

    crp_tagger u_tagger (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (do_fresh),
        .character (fresh_char),
        .tag       (fresh_tag)
    );

    crp_hist_mem #(
        .DEPTH (DEPTH)
    ) u_hist_mem (
        .clk     (clk),
        .wr_en   (do_fresh),
        .wr_addr (tail_reg),
        .wr_data (wr_entry),
        .rd_en   (do_replay),
        .rd_addr (tail_reg),
        .rd_data (rd_entry)
    );

    always_comb
    begin
        tail_next      = tail_reg;
        hist_cnt_next  = hist_cnt_reg;
        pb_cnt_next    = pb_cnt_reg;
        rd_pend_next   = do_replay;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (in_accept)
        begin
            if (in_data.opcode == OP_PUSHBACK)
            begin
                if (hist_cnt_reg != '0)
                begin
                    tail_next     = tail_dec;
                    hist_cnt_next = hist_cnt_reg - CW'(1);
                    pb_cnt_next   = pb_cnt_reg + CW'(1);
                end
            end
            else
            begin
                tail_next = tail_inc;
                if (hist_cnt_reg != CW'(DEPTH))
                begin
                    hist_cnt_next = hist_cnt_reg + CW'(1);
                end
                if (pb_cnt_reg != '0)
                begin
                    pb_cnt_next = pb_cnt_reg - CW'(1);
                end
            end
        end

        if (do_fresh)
        begin
            out_valid_next              = 1'b1;
            out_data_next.character     = fresh_char;
            out_data_next.line          = fresh_tag.line;
            out_data_next.column        = fresh_tag.column;
            out_data_next.position      = fresh_tag.position;
            out_data_next.from_pushback = 1'b0;
        end
        else if (rd_pend_reg)
        begin
            out_valid_next              = 1'b1;
            out_data_next.character     = rd_entry.character;
            out_data_next.line          = rd_entry.tag.line;
            out_data_next.column        = rd_entry.tag.column;
            out_data_next.position      = rd_entry.tag.position;
            out_data_next.from_pushback = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_code_reg <= INVALID_CODE_RESET;
            tail_reg         <= '0;
            hist_cnt_reg     <= '0;
            pb_cnt_reg       <= '0;
            rd_pend_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                invalid_code_reg <= cfg_wdata;
            end
            tail_reg      <= tail_next;
            hist_cnt_reg  <= hist_cnt_next;
            pb_cnt_reg    <= pb_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The history and the pending pushbacks share the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(hist_cnt_reg) + (CW + 1)'(pb_cnt_reg) <= (CW + 1)'(DEPTH))
        else $error("ring occupancy exceeds its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        do_replay |=> rd_pend_reg && out_valid_next)
        else $error("replay read did not complete");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !(out_valid_reg && out_stall))
        else $error("replay data arrived while the output was still held");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |=> out_valid_reg && out_data_reg.from_pushback)
        else $error("replayed word not presented");

endmodule

[hw/rtl/crp_hist_mem.sv]
// ----------------------------------------------------------------------------
// crp_hist_mem
// History ring storage: one write port and one read port, read data
// registered in the cycle after the read request.
// ----------------------------------------------------------------------------
module crp_hist_mem #(
    parameter int DEPTH = 128
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  crp_pkg::hist_entry_t         wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output crp_pkg::hist_entry_t         rd_data
);
    import crp_pkg::*;

    hist_entry_t mem [DEPTH];
    hist_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/crp_tagger.sv]
// ----------------------------------------------------------------------------
// crp_tagger
// Line, column and position counters. Gives the tag of the character being
// taken and advances the counters, saturating, when it is taken.
// ----------------------------------------------------------------------------
module crp_tagger (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [crp_pkg::CHAR_W-1:0]    character,
    output crp_pkg::tag_t                 tag
);
    import crp_pkg::*;

    logic [LINE_W-1:0] line_reg,   line_next;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [COL_W-1:0]  column_inc;
    logic [POS_W-1:0]  pos_inc;
    logic [LINE_W-1:0] line_inc;

    always_comb
    begin
        column_inc = (column_reg == '1) ? column_reg : column_reg + COL_W'(1);
        pos_inc    = (pos_reg == '1) ? pos_reg : pos_reg + POS_W'(1);
        line_inc   = (line_reg == '1) ? line_reg : line_reg + LINE_W'(1);

        tag.line     = line_reg;
        tag.column   = column_inc;
        tag.position = pos_inc;

        line_next   = line_reg;
        column_next = column_reg;
        pos_next    = pos_reg;
        if (take)
        begin
            pos_next = pos_inc;
            if (character == NEWLINE_CODE)
            begin
                line_next   = line_inc;
                column_next = '0;
            end
            else
            begin
                column_next = column_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= LINE_W'(1);
            column_reg <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            line_reg   <= line_next;
            column_reg <= column_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

[dv/char_reader_with_pushback_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_reader_with_pushback_top_test
// Self-checking bench for the pushback character reader. A scoreboard keeps
// its own history ring, pushback depth and line, column and position counters.
// It predicts every tagged character, and each word that leaves the block is
// compared field by field. Directed words cover the field extremes, newlines,
// read errors, replays and push backs on an empty history. Random words then
// run under several error codes, with random idling on both sides. A long
// output hold backs the block up into its input.
// ----------------------------------------------------------------------------
module char_reader_with_pushback_top_test;
    import crp_pkg::*;

    localparam int RING_DEPTH  = 128;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT    = 36;

    class reader_scoreboard;
        hist_entry_t       ring [RING_DEPTH];
        int unsigned       tail;
        int unsigned       history_len;
        int unsigned       pushed_back;
        logic [LINE_W-1:0] line_cnt;
        logic [COL_W-1:0]  col_cnt;
        logic [POS_W-1:0]  pos_cnt;
        logic [CHAR_W-1:0] invalid_code;
        out_word_t         tagged_chars [$];
        int unsigned       errors;

        function new();
            tail         = 0;
            history_len  = 0;
            pushed_back  = 0;
            line_cnt     = LINE_W'(1);
            col_cnt      = '0;
            pos_cnt      = '0;
            invalid_code = INVALID_CODE_RESET;
            errors       = 0;
        endfunction

        function void take_word(in_word_t w);
            hist_entry_t e;
            out_word_t   o;
            logic        replay;
            if (w.opcode == OP_PUSHBACK)
            begin
                if (history_len != 0)
                begin
                    tail = (tail == 0) ? RING_DEPTH - 1 : tail - 1;
                    history_len--;
                    pushed_back++;
                end
                return;
            end
            if (pushed_back != 0)
            begin
                e = ring[tail];
                pushed_back--;
                replay = 1'b1;
            end
            else
            begin
                e.character = w.source_error ? invalid_code : w.source_char;
                if (col_cnt != '1)
                    col_cnt++;
                if (pos_cnt != '1)
                    pos_cnt++;
                e.tag.line     = line_cnt;
                e.tag.column   = col_cnt;
                e.tag.position = pos_cnt;
                if (e.character == NEWLINE_CODE)
                begin
                    if (line_cnt != '1)
                        line_cnt++;
                    col_cnt = '0;
                end
                ring[tail] = e;
                replay = 1'b0;
            end
            tail = (tail + 1 == RING_DEPTH) ? 0 : tail + 1;
            if (history_len < RING_DEPTH)
                history_len++;
            o.character     = e.character;
            o.line          = e.tag.line;
            o.column        = e.tag.column;
            o.position      = e.tag.position;
            o.from_pushback = replay;
            tagged_chars.push_back(o);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void compare_char(out_word_t got);
            out_word_t want;
            if (tagged_chars.size() == 0)
            begin
                $error("character %0h arrived with none outstanding", got.character);
                errors++;
                return;
            end
            want = tagged_chars.pop_front();
            check_field("character", 32'(want.character), 32'(got.character));
            check_field("line", 32'(want.line), 32'(got.line));
            check_field("column", 32'(want.column), 32'(got.column));
            check_field("position", want.position, got.position);
            check_field("from_pushback", 32'(want.from_pushback),
                        32'(got.from_pushback));
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [CHAR_W-1:0] cfg_wdata = '0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_data;

    reader_scoreboard board = new();
    bit steady       = 1'b0;
    bit hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    char_reader_with_pushback_top #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.compare_char(out_data);
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic in_word_t next_word(logic [CHAR_W-1:0] ch, logic err);
        in_word_t w;
        w.opcode       = OP_NEXT;
        w.source_char  = ch;
        w.source_error = err;
        return w;
    endfunction

    function automatic in_word_t pushback_word();
        in_word_t w;
        w.opcode       = OP_PUSHBACK;
        w.source_char  = CHAR_W'($urandom);
        w.source_error = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic in_word_t fresh_word();
        int unsigned       pick;
        logic [CHAR_W-1:0] ch;
        pick = $urandom_range(99);
        if (pick < 15)
            ch = NEWLINE_CODE;
        else if (pick < 50)
            ch = CHAR_W'($urandom_range(32, 126));
        else if (pick < 60)
            ch = pick[0] ? '1 : '0;
        else
            ch = CHAR_W'($urandom);
        return next_word(ch, $urandom_range(99) < 8);
    endfunction

    task automatic send_word(in_word_t w);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.take_word(w);
    endtask

    task automatic write_invalid_code(logic [CHAR_W-1:0] code);
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.tagged_chars.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.invalid_code = code;
    endtask

    task automatic random_words(int budget);
        int sent;
        int pick;
        int run;
        int backs;
        int extra;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                backs = $urandom_range(120, 135);
                repeat (backs) send_word(pushback_word());
                repeat (backs + 5) send_word(fresh_word());
                sent += 2 * backs + 5;
            end
            else if (pick < 70)
            begin
                run   = $urandom_range(1, 12);
                backs = $urandom_range(1, 8);
                extra = $urandom_range(4);
                repeat (run) send_word(fresh_word());
                repeat (backs) send_word(pushback_word());
                repeat (backs + extra) send_word(fresh_word());
                sent += run + 2 * backs + extra;
            end
            else
            begin
                run = $urandom_range(1, 6);
                repeat (run)
                begin
                    if ($urandom_range(1))
                        send_word(pushback_word());
                    else
                        send_word(fresh_word());
                end
                sent += run;
            end
        end
    endtask

    initial
    begin
        in_word_t directed [$];
        directed.push_back(pushback_word());
        directed.push_back(next_word('0, 1'b0));
        directed.push_back(next_word('1, 1'b0));
        directed.push_back(next_word(NEWLINE_CODE, 1'b0));
        directed.push_back(next_word(CHAR_W'(21'h155555), 1'b1));
        directed.push_back(next_word(CHAR_W'(65), 1'b0));
        directed.push_back(pushback_word());
        directed.push_back(next_word(CHAR_W'(21'h0AAAAA), 1'b0));
        repeat (3) directed.push_back(pushback_word());
        repeat (4) directed.push_back(next_word(CHAR_W'(66), 1'b0));
        directed.push_back(next_word(NEWLINE_CODE, 1'b1));
        directed.push_back(next_word(NEWLINE_CODE, 1'b0));
        repeat (2) directed.push_back(pushback_word());
        repeat (2) directed.push_back(next_word('1, 1'b1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i]);
        random_words(200);

        write_invalid_code(NEWLINE_CODE);
        send_word(next_word(CHAR_W'(67), 1'b1));
        send_word(pushback_word());
        send_word(next_word(CHAR_W'(68), 1'b0));
        send_word(next_word(CHAR_W'(69), 1'b1));
        random_words(150);

        write_invalid_code('0);
        steady       = 1'b1;
        hold_request = 1'b1;
        repeat (150) send_word(fresh_word());
        steady = 1'b0;
        random_words(150);

        write_invalid_code('1);
        steady = 1'b1;
        random_words(150);
        steady = 1'b0;
        random_words(150);

        write_invalid_code(CHAR_W'($urandom));
        random_words(150);

        in_valid <= 1'b0;
        @(posedge clk);
        while (board.tagged_chars.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
